// File: hdl/msci_pkg.sv
// shared types and constants of the marching squares case index block
package msci_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_ROWS  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_COLS  = 2'd1;
  localparam logic [1:0] CFG_SAMPLE_STEP = 2'd2;
  localparam logic [1:0] CFG_THRESHOLD   = 2'd3;

  // register reset values
  localparam logic [11:0] ROWS_RESET      = 12'd2048;
  localparam logic [11:0] COLS_RESET      = 12'd2048;
  localparam logic [6:0]  STEP_RESET      = 7'd8;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd200;

  // legal ranges that the registers are clamped to
  localparam logic [11:0] SIZE_MIN = 12'd2;
  localparam logic [11:0] SIZE_MAX = 12'd2048;
  localparam logic [6:0]  STEP_MIN = 7'd2;
  localparam logic [6:0]  STEP_MAX = 7'd64;

  // line buffer read request
  typedef struct packed {
    logic        en;
    logic [10:0] idx;
  } lb_rd_t;

  // line buffer write request
  typedef struct packed {
    logic        en;
    logic [10:0] idx;
    logic        data;
  } lb_wr_t;

  // sample point waiting for its line buffer read
  typedef struct packed {
    logic        sample;
    logic        emit;
    logic        pt_bit;
    logic        last;
    logic [10:0] gcol;
    logic [9:0]  crow;
    logic [9:0]  ccol;
  } s1_t;

endpackage

// File: hdl/msci_line_buf.sv
// line buffer holding the grid point bits of the previous grid row
module msci_line_buf #(
  parameter int LINE_DEPTH = 2048
) (
  input  logic            clk,
  input  msci_pkg::lb_rd_t rd,
  input  msci_pkg::lb_wr_t wr,
  output logic            rd_bit
);

  localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int IW = (AW + 1 > 11) ? AW + 1 : 11;

  logic          mem [LINE_DEPTH];
  logic          rd_bit_r;
  logic [IW-1:0] rd_ext;
  logic [IW-1:0] wr_ext;
  logic          rd_in;
  logic          wr_in;
  logic          fwd;

  assign rd_ext = IW'(rd.idx);
  assign wr_ext = IW'(wr.idx);
  // entries past the depth: writes dropped, reads give zero
  assign rd_in  = rd_ext < IW'(LINE_DEPTH);
  assign wr_in  = wr_ext < IW'(LINE_DEPTH);
  // write and read of one entry at the same edge
  assign fwd    = wr.en && wr_in && (wr.idx == rd.idx);

  always_ff @(posedge clk) begin
    if (wr.en && wr_in) begin
      mem[wr_ext[AW-1:0]] <= wr.data;
    end
    if (rd.en) begin
      rd_bit_r <= rd_in ? (fwd ? wr.data : mem[rd_ext[AW-1:0]]) : 1'b0;
    end
  end

  assign rd_bit = rd_bit_r;

endmodule

// File: hdl/marching_squares_case_index_core.sv
// marching squares case index core: pixel stream in, cell case indexes out
// a cell's request goes through stage one and then the output register
// throughput: one pixel per cycle while in_stall is low, set by the single line buffer
// read and write each cycle; pixels that are no sample point give no request
// reset: synchronous active-low rst_n clears counters, pipeline and output valid
// and restores register defaults; the line buffer is not cleared
module marching_squares_case_index_core #(
  parameter int LINE_DEPTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  // pixel input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  // cell output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_case_index,
  output logic [9:0]  out_cell_row,
  output logic [9:0]  out_cell_col,
  output logic        out_last_cell,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  // configuration registers
  logic [11:0] image_rows_r, image_rows_nxt;
  logic [11:0] image_cols_r, image_cols_nxt;
  logic [6:0]  sample_step_r, sample_step_nxt;
  logic [7:0]  threshold_r, threshold_nxt;

  // raster and grid position
  logic [10:0] pixel_row_r, pixel_row_nxt;
  logic [10:0] pixel_col_r, pixel_col_nxt;
  logic [5:0]  row_phase_r, row_phase_nxt;
  logic [5:0]  col_phase_r, col_phase_nxt;
  logic [10:0] grid_row_r, grid_row_nxt;
  logic [10:0] grid_col_r, grid_col_nxt;

  // neighbour bits, updated in stage one in request order
  logic        left_r, left_nxt;
  logic        diag_r, diag_nxt;

  // stage one and output register
  logic        s1_valid_r, s1_valid_nxt;
  msci_pkg::s1_t s1_r, s1_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_case_r, out_case_nxt;
  logic [9:0]  out_row_r, out_row_nxt;
  logic [9:0]  out_col_r, out_col_nxt;
  logic        out_last_r, out_last_nxt;

  // stage zero decode
  logic [11:0] rows_c, cols_c;
  logic [6:0]  step_c;
  logic [11:0] pr_ext, pc_ext;
  logic        last_row, last_col, reg_row, reg_col, sample;
  logic [9:0]  gray_sum, gray_lim;
  logic        pt_bit;
  logic [6:0]  row_ph_inc, col_ph_inc;
  logic [10:0] grow_m1, gcol_m1;

  logic        in_accept, s1_adv, tr_bit;
  msci_pkg::lb_rd_t lb_rd;
  msci_pkg::lb_wr_t lb_wr;

  assign cfg_ready = 1'b1;

  // clamp the registers to their legal ranges
  always_comb begin
    rows_c = (image_rows_r < msci_pkg::SIZE_MIN) ? msci_pkg::SIZE_MIN :
             (image_rows_r > msci_pkg::SIZE_MAX) ? msci_pkg::SIZE_MAX : image_rows_r;
    cols_c = (image_cols_r < msci_pkg::SIZE_MIN) ? msci_pkg::SIZE_MIN :
             (image_cols_r > msci_pkg::SIZE_MAX) ? msci_pkg::SIZE_MAX : image_cols_r;
    step_c = (sample_step_r < msci_pkg::STEP_MIN) ? msci_pkg::STEP_MIN :
             (sample_step_r > msci_pkg::STEP_MAX) ? msci_pkg::STEP_MAX : sample_step_r;
  end

  // sample point decode for the pixel on the input
  always_comb begin
    pr_ext   = {1'b0, pixel_row_r};
    pc_ext   = {1'b0, pixel_col_r};
    last_row = pr_ext >= (rows_c - 12'd1);
    last_col = pc_ext >= (cols_c - 12'd1);
    // a regular grid line needs a whole step left before the frame edge
    reg_row  = !last_row && (row_phase_r == 6'd0) && ((pr_ext + {5'd0, step_c}) <= rows_c);
    reg_col  = !last_col && (col_phase_r == 6'd0) && ((pc_ext + {5'd0, step_c}) <= cols_c);
    sample   = (reg_row || last_row) && (reg_col || last_col);
    // floor(sum/3) <= t is the same as sum <= 3t+2
    gray_sum = 10'(in_red) + 10'(in_green) + 10'(in_blue);
    gray_lim = ({2'd0, threshold_r} << 1) + {2'd0, threshold_r} + 10'd2;
    // bottom-right corner point is always outside
    pt_bit   = (gray_sum <= gray_lim) && !(last_row && last_col);
    row_ph_inc = {1'b0, row_phase_r} + 7'd1;
    col_ph_inc = {1'b0, col_phase_r} + 7'd1;
    grow_m1  = grid_row_r - 11'd1;
    gcol_m1  = grid_col_r - 11'd1;
  end

  // handshake: stage one moves on unless its cell finds the output full and stalled
  assign s1_adv    = s1_valid_r && (!s1_r.emit || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // line buffer: read on accepting a sample point, write back when it leaves stage one
  assign lb_rd.en   = in_accept && sample;
  assign lb_rd.idx  = grid_col_r;
  assign lb_wr.en   = s1_adv && s1_r.sample;
  assign lb_wr.idx  = s1_r.gcol;
  assign lb_wr.data = s1_r.pt_bit;

  msci_line_buf #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_line_buf (
    .clk    (clk),
    .rd     (lb_rd),
    .wr     (lb_wr),
    .rd_bit (tr_bit)
  );

  // next state
  always_comb begin
    image_rows_nxt  = image_rows_r;
    image_cols_nxt  = image_cols_r;
    sample_step_nxt = sample_step_r;
    threshold_nxt   = threshold_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        msci_pkg::CFG_IMAGE_ROWS:  image_rows_nxt  = cfg_data;
        msci_pkg::CFG_IMAGE_COLS:  image_cols_nxt  = cfg_data;
        msci_pkg::CFG_SAMPLE_STEP: sample_step_nxt = cfg_data[6:0];
        msci_pkg::CFG_THRESHOLD:   threshold_nxt   = cfg_data[7:0];
      endcase
    end

    pixel_row_nxt = pixel_row_r;
    pixel_col_nxt = pixel_col_r;
    row_phase_nxt = row_phase_r;
    col_phase_nxt = col_phase_r;
    grid_row_nxt  = grid_row_r;
    grid_col_nxt  = grid_col_r;
    if (in_accept) begin
      if (sample && reg_col) begin
        grid_col_nxt = grid_col_r + 11'd1;
      end
      if (last_col) begin
        // end of a pixel row
        pixel_col_nxt = 11'd0;
        col_phase_nxt = 6'd0;
        grid_col_nxt  = 11'd0;
        if (last_row) begin
          // end of frame
          pixel_row_nxt = 11'd0;
          row_phase_nxt = 6'd0;
          grid_row_nxt  = 11'd0;
        end else begin
          if (reg_row) begin
            grid_row_nxt = grid_row_r + 11'd1;
          end
          row_phase_nxt = (row_ph_inc >= step_c) ? 6'd0 : row_ph_inc[5:0];
          pixel_row_nxt = pixel_row_r + 11'd1;
        end
      end else begin
        col_phase_nxt = (col_ph_inc >= step_c) ? 6'd0 : col_ph_inc[5:0];
        pixel_col_nxt = pixel_col_r + 11'd1;
      end
    end

    // stage one load
    s1_valid_nxt = in_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    s1_nxt       = s1_r;
    if (in_accept) begin
      s1_nxt.sample = sample;
      s1_nxt.emit   = sample && (grid_row_r != 11'd0) && (grid_col_r != 11'd0);
      s1_nxt.pt_bit = pt_bit;
      s1_nxt.last   = last_row && last_col;
      s1_nxt.gcol   = grid_col_r;
      s1_nxt.crow   = grow_m1[9:0];
      s1_nxt.ccol   = gcol_m1[9:0];
    end

    // neighbour bits follow the sample points in order
    left_nxt = left_r;
    diag_nxt = diag_r;
    if (s1_adv && s1_r.sample) begin
      left_nxt = s1_r.pt_bit;
      diag_nxt = tr_bit;
    end

    // output register
    out_valid_nxt = out_valid_r && out_stall;
    out_case_nxt  = out_case_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;
    if (s1_adv && s1_r.emit) begin
      out_valid_nxt = 1'b1;
      out_case_nxt  = {diag_r, tr_bit, s1_r.pt_bit, left_r};
      out_row_nxt   = s1_r.crow;
      out_col_nxt   = s1_r.ccol;
      out_last_nxt  = s1_r.last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_rows_r  <= msci_pkg::ROWS_RESET;
      image_cols_r  <= msci_pkg::COLS_RESET;
      sample_step_r <= msci_pkg::STEP_RESET;
      threshold_r   <= msci_pkg::THRESHOLD_RESET;
      pixel_row_r   <= 11'd0;
      pixel_col_r   <= 11'd0;
      row_phase_r   <= 6'd0;
      col_phase_r   <= 6'd0;
      grid_row_r    <= 11'd0;
      grid_col_r    <= 11'd0;
      left_r        <= 1'b0;
      diag_r        <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      image_rows_r  <= image_rows_nxt;
      image_cols_r  <= image_cols_nxt;
      sample_step_r <= sample_step_nxt;
      threshold_r   <= threshold_nxt;
      pixel_row_r   <= pixel_row_nxt;
      pixel_col_r   <= pixel_col_nxt;
      row_phase_r   <= row_phase_nxt;
      col_phase_r   <= col_phase_nxt;
      grid_row_r    <= grid_row_nxt;
      grid_col_r    <= grid_col_nxt;
      left_r        <= left_nxt;
      diag_r        <= diag_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    out_case_r <= out_case_nxt;
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_case_index = out_case_r;
  assign out_cell_row   = out_row_r;
  assign out_cell_col   = out_col_r;
  assign out_last_cell  = out_last_r;

endmodule
